@@ hw/rtl/vrot_pkg.sv @@
// Shared widths, axis codes, item types and the CORDIC arctangent table
// for the axis rotation block. Depends on nothing.
package vrot_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 8;
  // Only up to 32 stages ever run
  localparam int NSTAGE        = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SH_W          = $clog2(NSTAGE);
  // Datapath width: guard bits, one bit for negation, two for CORDIC growth
  localparam int CW            = DATA_WIDTH + GUARD + 3;
  // Residual angle, Q2.30 with headroom
  localparam int ZW            = 34;
  localparam int ANG_W         = 32;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] in_x;
    logic signed [DATA_WIDTH-1:0] in_y;
    logic signed [DATA_WIDTH-1:0] in_z;
    logic [1:0]                   mode;
    logic signed [ANG_W-1:0]      angle_deg;
  } vrot_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic                         bad_axis;
  } vrot_out_t;

  // Data carried along the CORDIC row: rotated pair, residual angle,
  // component on the axis and the axis code for final placement
  typedef struct packed {
    logic signed [CW-1:0]         u;
    logic signed [CW-1:0]         v;
    logic signed [ZW-1:0]         z;
    logic signed [DATA_WIDTH-1:0] w;
    logic [1:0]                   mode;
  } cordic_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'h3243F6A8;
      5'd1:    a = 30'h1DAC6705;
      5'd2:    a = 30'h0FADBAFC;
      5'd3:    a = 30'h07F56EA6;
      5'd4:    a = 30'h03FEAB76;
      5'd5:    a = 30'h01FFD55B;
      5'd6:    a = 30'h00FFFAAA;
      5'd7:    a = 30'h007FFF55;
      5'd8:    a = 30'h003FFFEA;
      5'd9:    a = 30'h001FFFFD;
      5'd10:   a = 30'h000FFFFF;
      5'd11:   a = 30'h0007FFFF;
      5'd12:   a = 30'h0003FFFF;
      5'd13:   a = 30'h0001FFFF;
      5'd14:   a = 30'h0000FFFF;
      5'd15:   a = 30'h00007FFF;
      5'd16:   a = 30'h00003FFF;
      5'd17:   a = 30'h00001FFF;
      5'd18:   a = 30'h00000FFF;
      5'd19:   a = 30'h000007FF;
      5'd20:   a = 30'h000003FF;
      5'd21:   a = 30'h000001FF;
      5'd22:   a = 30'h000000FF;
      5'd23:   a = 30'h0000007F;
      5'd24:   a = 30'h0000003F;
      5'd25:   a = 30'h0000001F;
      5'd26:   a = 30'h0000000F;
      5'd27:   a = 30'h00000008;
      5'd28:   a = 30'h00000004;
      5'd29:   a = 30'h00000002;
      5'd30:   a = 30'h00000001;
      default: a = 30'h00000000;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/vrot_angle.sv @@
// Front end: picks the rotated pair from the axis code, reduces the angle
// modulo 360 degrees, folds it into +-90 and converts it to Q2.30 radians.
// Depends on vrot_pkg.
module vrot_angle import vrot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     vld_i,
  input  vrot_in_t item_i,
  output logic     vld_o,
  output cordic_t  data_o
);

  localparam logic [15:0]        RECIP_360   = 16'd46603;   // floor(2^24 / 360)
  localparam logic [16:0]        DEG_OFFSET  = 17'd33120;   // 92 * 360
  localparam logic signed [25:0] DEG_FULL    = 26'sd23592960;
  localparam logic signed [25:0] DEG_HALF    = 26'sd11796480;
  localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;
  localparam logic [47:0]        DEG2RAD_Q30 = 48'd18740330;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] u;
    logic signed [DATA_WIDTH-1:0] v;
    logic signed [DATA_WIDTH-1:0] w;
    logic [1:0]                   mode;
  } side_t;

  logic [5:0]              vld_q;
  side_t                   side_d;
  side_t                   side_q [5];
  logic signed [ANG_W-1:0] deg_q;

  logic [16:0] hu_d, hu_q;
  logic [32:0] qprod;
  logic [8:0]  quo_q;
  logic [15:0] lo1_q, lo2_q;

  logic [16:0] rem_full;
  logic [9:0]  rem;
  logic [8:0]  rh_d, rh_q;

  logic signed [25:0] r_mod, r_fold, r_quad;
  logic [22:0]        mag_d, mag_q;
  logic               neg_d, flip_d, neg3_q, flip3_q, neg4_q, flip4_q;

  logic [47:0]          prod_d, prod_q;
  logic [31:0]          zmag;
  logic signed [CW-1:0] uw, vw;
  cordic_t              data_d, data_q;

  always_comb begin
    side_d.mode = item_i.mode;
    case (item_i.mode)
      AXIS_X: begin
        side_d.u = item_i.in_y;
        side_d.v = item_i.in_z;
        side_d.w = item_i.in_x;
      end
      AXIS_Y: begin
        side_d.u = item_i.in_z;
        side_d.v = item_i.in_x;
        side_d.w = item_i.in_y;
      end
      default: begin
        side_d.u = item_i.in_x;
        side_d.v = item_i.in_y;
        side_d.w = item_i.in_z;
      end
    endcase
  end

  // Whole-degree part plus an offset that is a multiple of 360 keeps it positive
  assign hu_d  = {deg_q[ANG_W-1], deg_q[ANG_W-1:16]} + DEG_OFFSET;
  assign qprod = 33'(hu_d) * 33'(RECIP_360);

  // Quotient estimate is low by at most one: one correction step
  assign rem_full = hu_q - 17'(quo_q) * 17'd360;
  assign rem      = rem_full[9:0];
  assign rh_d     = (rem >= 10'd360) ? 9'(rem - 10'd360) : rem[8:0];

  always_comb begin
    r_mod  = $signed({1'b0, rh_q, lo2_q});
    r_fold = (r_mod > DEG_HALF) ? r_mod - DEG_FULL : r_mod;
    flip_d = 1'b0;
    r_quad = r_fold;
    if (r_fold > DEG_QUARTER) begin
      flip_d = 1'b1;
      r_quad = r_fold - DEG_HALF;
    end else if (r_fold < -DEG_QUARTER) begin
      flip_d = 1'b1;
      r_quad = r_fold + DEG_HALF;
    end
    neg_d = r_quad[25];
    mag_d = neg_d ? 23'(-r_quad) : 23'(r_quad);
  end

  assign prod_d = 48'(mag_q) * DEG2RAD_Q30;

  always_comb begin
    zmag        = 32'((prod_q + 48'd32768) >> 16);
    uw          = CW'(side_q[4].u) <<< GUARD;
    vw          = CW'(side_q[4].v) <<< GUARD;
    data_d.u    = flip4_q ? -uw : uw;
    data_d.v    = flip4_q ? -vw : vw;
    data_d.z    = neg4_q ? -$signed(ZW'(zmag)) : $signed(ZW'(zmag));
    data_d.w    = side_q[4].w;
    data_d.mode = side_q[4].mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < 5; k++) begin
      side_q[k] <= side_q[k-1];
    end
    deg_q   <= item_i.angle_deg;
    hu_q    <= hu_d;
    quo_q   <= qprod[32:24];
    lo1_q   <= deg_q[15:0];
    rh_q    <= rh_d;
    lo2_q   <= lo1_q;
    mag_q   <= mag_d;
    neg3_q  <= neg_d;
    flip3_q <= flip_d;
    prod_q  <= prod_d;
    neg4_q  <= neg3_q;
    flip4_q <= flip3_q;
    data_q  <= data_d;
  end

  assign vld_o  = vld_q[5];
  assign data_o = data_q;

endmodule

@@ hw/rtl/vrot_cell.sv @@
// One CORDIC micro-rotation cell: shifts, adds and steps the residual angle,
// then registers the result for the next cell. Depends on vrot_pkg.
module vrot_cell import vrot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SH_W-1:0]      shift_i,
  input  logic signed [ZW-1:0] atan_i,
  input  logic                 vld_i,
  input  cordic_t              data_i,
  output logic                 vld_o,
  output cordic_t              data_o
);

  logic    vld_q;
  cordic_t data_d, data_q;

  // Both shifts take the values from before this step
  always_comb begin
    data_d = data_i;
    if (!data_i.z[ZW-1]) begin
      data_d.u = data_i.u - (data_i.v >>> shift_i);
      data_d.v = data_i.v + (data_i.u >>> shift_i);
      data_d.z = data_i.z - atan_i;
    end else begin
      data_d.u = data_i.u + (data_i.v >>> shift_i);
      data_d.v = data_i.v - (data_i.u >>> shift_i);
      data_d.z = data_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

@@ hw/rtl/vrot_gain.sv @@
// Back end: CORDIC gain correction, guard-bit rounding, saturation and
// placement of the pair back on the axes. Depends on vrot_pkg.
module vrot_gain import vrot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  cordic_t   data_i,
  output logic      vld_o,
  output vrot_out_t res_o
);

  localparam int LO_W = CW / 2;
  localparam int HI_W = CW - LO_W;
  localparam int SW   = CW + 31;
  localparam int SCW  = SW - 30;

  localparam logic [29:0]           GAIN_INV = 30'd652032874;
  localparam logic signed [30:0]    GAIN_S   = 31'sd652032874;
  localparam logic signed [SCW-1:0] HALF_LSB = SCW'(1) <<< (GUARD - 1);
  localparam logic signed [SCW-1:0] MAX_V    =
    {{(SCW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SCW-1:0] MIN_V    =
    {{(SCW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  logic [2:0]                   vld_q;
  logic signed [DATA_WIDTH-1:0] w_q  [2];
  logic [1:0]                   mode_q [2];

  logic signed [CW-1:0]         comp   [2];
  logic [LO_W+29:0]             plo_q  [2];
  logic signed [HI_W+30:0]      phi_q  [2];
  logic signed [SW-1:0]         sum    [2];
  logic signed [SCW-1:0]        scl_q  [2];
  logic signed [SCW-1:0]        rnd    [2];
  logic signed [DATA_WIDTH-1:0] sat    [2];
  vrot_out_t                    res_d, res_q;

  assign comp[0] = data_i.u;
  assign comp[1] = data_i.v;

  for (genvar k = 0; k < 2; k++) begin : g_lane
    // floor(c * gain / 2^30) as two partial products
    always_ff @(posedge clk_i) begin
      plo_q[k] <= (LO_W+30)'(comp[k][LO_W-1:0]) * (LO_W+30)'(GAIN_INV);
      phi_q[k] <= (HI_W+31)'($signed(comp[k][CW-1:LO_W])) * (HI_W+31)'(GAIN_S);
      scl_q[k] <= sum[k][SW-1:30];
    end

    assign sum[k] = (SW'(phi_q[k]) <<< LO_W) + SW'($signed({1'b0, plo_q[k]}));

    always_comb begin
      rnd[k] = (scl_q[k] + HALF_LSB) >>> GUARD;
      if (rnd[k] > MAX_V) begin
        sat[k] = MAX_V[DATA_WIDTH-1:0];
      end else if (rnd[k] < MIN_V) begin
        sat[k] = MIN_V[DATA_WIDTH-1:0];
      end else begin
        sat[k] = rnd[k][DATA_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    res_d.bad_axis = 1'b0;
    case (mode_q[1])
      AXIS_X: begin
        res_d.out_x = w_q[1];
        res_d.out_y = sat[0];
        res_d.out_z = sat[1];
      end
      AXIS_Y: begin
        res_d.out_x = sat[1];
        res_d.out_y = w_q[1];
        res_d.out_z = sat[0];
      end
      AXIS_Z: begin
        res_d.out_x = sat[0];
        res_d.out_y = sat[1];
        res_d.out_z = w_q[1];
      end
      default: begin
        res_d.out_x    = '0;
        res_d.out_y    = '0;
        res_d.out_z    = '0;
        res_d.bad_axis = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    w_q[0]    <= data_i.w;
    w_q[1]    <= w_q[0];
    mode_q[0] <= data_i.mode;
    mode_q[1] <= mode_q[0];
    res_q     <= res_d;
  end

  assign vld_o = vld_q[2];
  assign res_o = res_q;

endmodule

@@ hw/rtl/vector_rotation_about_axis.sv @@
// Top level of the axis rotation block: angle front end, a row of CORDIC
// cells and the gain and saturation back end. Depends on vrot_pkg,
// vrot_angle, vrot_cell and vrot_gain.
//
//   channel   | ports                          | transfer when
//   ----------+--------------------------------+-------------------------
//   item in   | start_i, busy_o, item_i        | start_i high, busy_o low
//   result    | done_o, result_o               | done_o high (one cycle)
//
// One item is taken every cycle; busy_o stays low.
// Each result passes through six front-end stages, one register per
// CORDIC cell and three back-end stages.
// Reset clears only the valid bits of the pipeline; nothing is in flight after it.
// The receiver cannot stall, so nothing holds the pipeline back.
module vector_rotation_about_axis import vrot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  vrot_in_t  item_i,
  output logic      done_o,
  output vrot_out_t result_o
);

  logic    c_vld  [NSTAGE+1];
  cordic_t c_data [NSTAGE+1];

  assign busy_o = 1'b0;

  vrot_angle u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i & ~busy_o),
    .item_i (item_i),
    .vld_o  (c_vld[0]),
    .data_o (c_data[0])
  );

  for (genvar k = 0; k < NSTAGE; k++) begin : g_cell
    vrot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (SH_W'(k)),
      .atan_i  ($signed(ZW'(atan_q30(5'(k))))),
      .vld_i   (c_vld[k]),
      .data_i  (c_data[k]),
      .vld_o   (c_vld[k+1]),
      .data_o  (c_data[k+1])
    );
  end

  vrot_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c_vld[NSTAGE]),
    .data_i (c_data[NSTAGE]),
    .vld_o  (done_o),
    .res_o  (result_o)
  );

endmodule

@@ verif/vector_rotation_about_axis_tb.sv @@
// Self-checking bench for vector_rotation_about_axis: drives vectors, axis codes and angles,
// predicts each rotated vector with a bit-exact fixed-point CORDIC of its own.
// Depends on vrot_pkg and the vector_rotation_about_axis RTL.
module vector_rotation_about_axis_tb;
  import vrot_pkg::*;

  localparam int LATENCY      = NSTAGE + 9;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 800;

  class rotation_scoreboard;
    localparam longint TURN_Q16    = 64'sd23592960;
    localparam longint HALF_Q16    = 64'sd11796480;
    localparam longint QUARTER_Q16 = 64'sd5898240;
    localparam longint RAD_PER_DEG = 64'sd18740330;
    localparam longint INV_GAIN    = 64'sd652032874;
    localparam int     STAGES      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    longint    atan_tab[32];
    vrot_out_t pending_vectors[$];
    int        failures;
    int        compared;
    int        axis_seen[4];

    function new();
      atan_tab = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000};
      failures = 0;
      compared = 0;
      axis_seen = '{0, 0, 0, 0};
    endfunction

    // Remove the CORDIC gain, drop the guard bits with round half up, then clamp
    function longint gain_round_clamp(input longint c);
      longint hi, lo, scaled, r, maxv;
      hi     = c >>> 30;
      lo     = c - (hi <<< 30);
      scaled = hi * INV_GAIN + ((lo * INV_GAIN) >>> 30);
      r      = (scaled + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      maxv   = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
      if (r > maxv) r = maxv;
      if (r < -maxv - 1) r = -maxv - 1;
      return r;
    endfunction

    task rotate_components(inout longint u, inout longint v, input longint deg);
      longint r, mag, z, du, dv;
      u = u <<< GUARD;
      v = v <<< GUARD;
      r = deg % TURN_Q16;
      if (r < 0) r += TURN_Q16;
      if (r > HALF_Q16) r -= TURN_Q16;
      // Fold into the CORDIC range by a half turn
      if (r > QUARTER_Q16) begin
        u = -u; v = -v; r -= HALF_Q16;
      end else if (r < -QUARTER_Q16) begin
        u = -u; v = -v; r += HALF_Q16;
      end
      mag = (r < 0) ? -r : r;
      z = (mag * RAD_PER_DEG + 64'sd32768) >>> 16;
      if (r < 0) z = -z;
      for (int i = 0; i < STAGES; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (z >= 0) begin
          u -= du; v += dv; z -= atan_tab[i];
        end else begin
          u += du; v -= dv; z += atan_tab[i];
        end
      end
      u = gain_round_clamp(u);
      v = gain_round_clamp(v);
    endtask

    task note_item(input vrot_in_t it);
      vrot_out_t want;
      longint    x, y, z, deg;
      x   = longint'($signed(it.in_x));
      y   = longint'($signed(it.in_y));
      z   = longint'($signed(it.in_z));
      deg = longint'($signed(it.angle_deg));
      want.bad_axis = 1'b0;
      case (it.mode)
        AXIS_X: rotate_components(y, z, deg);
        AXIS_Y: rotate_components(z, x, deg);
        AXIS_Z: rotate_components(x, y, deg);
        default: begin
          x = 0; y = 0; z = 0; want.bad_axis = 1'b1;
        end
      endcase
      want.out_x = x[DATA_WIDTH-1:0];
      want.out_y = y[DATA_WIDTH-1:0];
      want.out_z = z[DATA_WIDTH-1:0];
      axis_seen[it.mode]++;
      pending_vectors.push_back(want);
    endtask

    function void check_result(input vrot_out_t got);
      vrot_out_t want;
      if (pending_vectors.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result x=%h y=%h z=%h bad=%b",
                   got.out_x, got.out_y, got.out_z, got.bad_axis);
        return;
      end
      want = pending_vectors.pop_front();
      compared++;
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.bad_axis !== want.bad_axis) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: want x=%h y=%h z=%h bad=%b, got x=%h y=%h z=%h bad=%b",
                   compared, want.out_x, want.out_y, want.out_z, want.bad_axis,
                   got.out_x, got.out_y, got.out_z, got.bad_axis);
      end
    endfunction

    function int pending_count();
      return pending_vectors.size();
    endfunction

    function void flush_leftovers();
      if (pending_vectors.size() != 0) begin
        failures += pending_vectors.size();
        $display("%0d results never arrived", pending_vectors.size());
        pending_vectors.delete();
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  vrot_in_t  item_i  = '0;
  logic      busy_o;
  logic      done_o;
  vrot_out_t result_o;

  rotation_scoreboard sb = new();
  int quiet_cycles = 0;

  vector_rotation_about_axis uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check results before noting new transfers; the pipeline keeps them apart anyway
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(result_o);
      if (start_i && !busy_o) sb.note_item(item_i);
      if (done_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("vector_rotation_about_axis verification failed");
    $finish;
  end

  function automatic vrot_in_t make_item(input int x, input int y, input int z,
                                         input logic [1:0] axis, input int ang);
    vrot_in_t it;
    it.in_x      = x;
    it.in_y      = y;
    it.in_z      = z;
    it.mode      = axis;
    it.angle_deg = ang;
    return it;
  endfunction

  function automatic int random_component();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 0;
          default: return -1;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default: return int'($urandom_range(0, 2000 << 16)) - (1000 << 16);
    endcase
  endfunction

  function automatic vrot_in_t random_item();
    logic [1:0] axis;
    int         ang;
    axis = ($urandom_range(0, 9) == 0) ? AXIS_BAD : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0, 1, 2: ang = $urandom;
      3, 4, 5, 6: ang = int'($urandom_range(0, 1440 << 16)) - (720 << 16);
      // Land close to the quadrant boundaries
      default: ang = ((int'($urandom_range(0, 16)) - 8) * (90 << 16))
                     + int'($urandom_range(0, 8)) - 4;
    endcase
    return make_item(random_component(), random_component(), random_component(), axis, ang);
  endfunction

  task automatic send_item(input vrot_in_t it);
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold start low with junk on the item bus
  task automatic idle_for(input int cycles);
    start_i <= 1'b0;
    item_i  <= random_item();
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop start only if it is still raised from the last transfer
  task automatic wait_for_drain();
    if (start_i) start_i <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
  endtask

  initial begin
    int one, vmax, vmin, sent, burst, gap;
    bit paused;
    one  = 1 << 16;
    vmax = 32'sh7FFFFFFF;
    vmin = 32'sh80000000;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Quadrant edges, wrap-around, saturation and the invalid axis
    send_item(make_item(one, 2 * one, 3 * one, AXIS_X, 0));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_Y, 90 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_Z, -90 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_X, 180 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_Y, -180 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_Z, 360 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_X, 45 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_Y, 270 * one));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_Z, 90 * one + 1));
    send_item(make_item(one, 2 * one, 3 * one, AXIS_X, -90 * one - 1));
    send_item(make_item(vmax, vmax, vmax, AXIS_Z, 45 * one));
    send_item(make_item(vmin, vmin, vmin, AXIS_X, 45 * one));
    send_item(make_item(vmin, vmax, vmin, AXIS_Y, 180 * one));
    send_item(make_item(vmax, vmin, vmax, AXIS_Z, vmax));
    send_item(make_item(-1, -1, -1, AXIS_X, vmin));
    send_item(make_item(0, 0, 0, AXIS_Y, 30 * one));
    send_item(make_item(vmax, vmin, one, AXIS_BAD, 45 * one));
    send_item(make_item(-one, one, -1, AXIS_BAD, vmin));
    send_item(make_item(5 * one, -7 * one, one, AXIS_Z, -1080 * one + 1));
    send_item(make_item(5 * one, -7 * one, one, AXIS_Y, 1));
    send_item(make_item(5 * one, -7 * one, one, AXIS_X, -1));
    send_item(make_item(123456, -654321, 777, AXIS_Z, 135 * one));
    wait_for_drain();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 32);
      for (int i = 0; i < burst; i++) begin
        send_item(random_item());
        sent++;
      end
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        3: gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) idle_for(gap);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
    start_i <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    sb.flush_leftovers();

    $display("%0d vectors in (x %0d, y %0d, z %0d, invalid axis %0d), %0d results compared",
             sb.axis_seen[0] + sb.axis_seen[1] + sb.axis_seen[2] + sb.axis_seen[3],
             sb.axis_seen[0], sb.axis_seen[1], sb.axis_seen[2], sb.axis_seen[3], sb.compared);
    $display("%0d failures over directed edge cases and random bursts", sb.failures);
    if (sb.failures == 0)
      $display("vector_rotation_about_axis verification clean");
    else
      $display("vector_rotation_about_axis verification failed");
    $finish;
  end

endmodule
